[src/scl_pkg.sv]
// Shared types, codes and character helpers for the shell command lexer.
package scl_pkg;

    // Lexer mode held between beats
    typedef enum logic [2:0] {
        MODE_WAIT  = 3'd0,
        MODE_WORD  = 3'd1,
        MODE_DELIM = 3'd2,
        MODE_DBL   = 3'd3,
        MODE_ESC   = 3'd4
    } mode_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FLUSH,
        ST_ERR
    } state_t;

    // Result status codes
    localparam logic [1:0] STAT_TOKEN     = 2'd0;
    localparam logic [1:0] STAT_BAD_CHAR  = 2'd1;
    localparam logic [1:0] STAT_AFTER_END = 2'd2;

    // Token type codes
    localparam logic [3:0] TT_WORD   = 4'd0;
    localparam logic [3:0] TT_AMP    = 4'd1;
    localparam logic [3:0] TT_PIPE   = 4'd2;
    localparam logic [3:0] TT_SEMI   = 4'd3;
    localparam logic [3:0] TT_LT     = 4'd4;
    localparam logic [3:0] TT_GT     = 4'd5;
    localparam logic [3:0] TT_LPAR   = 4'd6;
    localparam logic [3:0] TT_RPAR   = 4'd7;
    localparam logic [3:0] TT_LBRACE = 4'd8;
    localparam logic [3:0] TT_RBRACE = 4'd9;
    localparam logic [3:0] TT_AND    = 4'd10;
    localparam logic [3:0] TT_OR     = 4'd11;
    localparam logic [3:0] TT_APPEND = 4'd12;

    // Characters of interest
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_TILDE  = 8'h7E;

    localparam int unsigned LINE_W = 16;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic load_err;
        logic load_byte;
        logic flush_done;
    } scl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic err_req;
        logic flush_req;
        logic out_free;
        logic flush_last;
    } scl_status_t;

    // Single delimiter character to its token type, TT_WORD if none
    function automatic logic [3:0] delim_type(input logic [7:0] c);
        logic [3:0] t;
        unique case (c)
            8'h26:   t = TT_AMP;
            8'h7C:   t = TT_PIPE;
            8'h3B:   t = TT_SEMI;
            8'h3C:   t = TT_LT;
            8'h3E:   t = TT_GT;
            8'h28:   t = TT_LPAR;
            8'h29:   t = TT_RPAR;
            8'h7B:   t = TT_LBRACE;
            8'h7D:   t = TT_RBRACE;
            default: t = TT_WORD;
        endcase
        return t;
    endfunction

    // Doubled delimiter type from the single type
    function automatic logic [3:0] pair_type(input logic [3:0] dt);
        logic [3:0] t;
        unique case (dt)
            TT_AMP:  t = TT_AND;
            TT_PIPE: t = TT_OR;
            TT_GT:   t = TT_APPEND;
            default: t = TT_WORD;
        endcase
        return t;
    endfunction

endpackage

[src/scl_ram.sv]
// Generic simple dual-port RAM with registered read.
module scl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/scl_ctrl.sv]
// Controller state machine: accepts beats and sequences token read-out and errors.
module scl_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  scl_pkg::scl_status_t status_i,
    output scl_pkg::scl_cmd_t    cmd_o
);

    scl_pkg::state_t state_reg;
    scl_pkg::state_t state_next;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            scl_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    if (status_i.err_req) begin
                        state_next = scl_pkg::ST_ERR;
                    end else if (status_i.flush_req) begin
                        state_next = scl_pkg::ST_FLUSH;
                    end
                end
            end
            scl_pkg::ST_FLUSH: begin
                if (status_i.out_free && status_i.flush_last) begin
                    state_next = scl_pkg::ST_IDLE;
                end
            end
            scl_pkg::ST_ERR: begin
                if (status_i.out_free) begin
                    state_next = scl_pkg::ST_IDLE;
                end
            end
            default: state_next = scl_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        s_tready         = 1'b0;
        cmd_o.accept     = 1'b0;
        cmd_o.load_err   = 1'b0;
        cmd_o.load_byte  = 1'b0;
        cmd_o.flush_done = 1'b0;
        unique case (state_reg)
            scl_pkg::ST_IDLE: begin
                s_tready     = 1'b1;
                cmd_o.accept = s_tvalid;
            end
            scl_pkg::ST_FLUSH: begin
                cmd_o.load_byte  = status_i.out_free;
                cmd_o.flush_done = status_i.out_free && status_i.flush_last;
            end
            scl_pkg::ST_ERR: begin
                cmd_o.load_err = status_i.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= scl_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[src/scl_datapath.sv]
// Datapath: character decode, lexer state, word store and output register.
module scl_datapath #(
    parameter int MAX_WORD = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [7:0]           s_tdata,
    input  logic                 s_tuser,
    input  scl_pkg::scl_cmd_t    cmd_i,
    output scl_pkg::scl_status_t status_o,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata,
    output logic [7:0]           m_tuser,
    output logic                 m_tlast
);

    localparam int AW = $clog2(MAX_WORD);
    localparam int CW = $clog2(MAX_WORD + 1);
    localparam int LW = scl_pkg::LINE_W;

    // Lexer state
    scl_pkg::mode_t mode_reg, mode_next;
    logic           quotes_reg, quotes_next;
    logic           halted_reg, halted_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           ovf_reg, ovf_next;
    logic [LW-1:0]  line_reg, line_next;
    logic [3:0]     dtype_reg, dtype_next;

    // Per-token control
    logic [3:0]     ftype_reg, ftype_next;
    logic           pend_reg, pend_next;
    logic [7:0]     pend_char_reg, pend_char_next;
    logic [AW-1:0]  ptr_reg, ptr_next;
    logic [1:0]     err_stat_reg, err_stat_next;

    // Output register
    logic           out_valid_reg, out_valid_next;
    logic [1:0]     out_status_reg, out_status_next;
    logic [3:0]     out_type_reg, out_type_next;
    logic [7:0]     out_byte_reg, out_byte_next;
    logic           out_empty_reg, out_empty_next;
    logic [LW-1:0]  out_line_reg, out_line_next;
    logic           out_ovf_reg, out_ovf_next;
    logic           out_last_reg, out_last_next;

    // Word store ports
    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [7:0]     ram_wdata;
    logic [7:0]     ram_rdata;

    // Decode signals
    logic           eos, is_esc, nl, ws, dl, prt, spc, bad;
    logic           is_quote, is_bsl, pair;
    logic [7:0]     c;
    logic [3:0]     dt;
    logic           st_append;
    scl_pkg::mode_t st_mode;
    logic           do_flush, do_append, set_halt;
    logic [3:0]     flush_type;
    scl_pkg::mode_t mode_dec;
    logic           quotes_dec;
    logic           count_empty, flush_last, room;

    // Character classification
    always_comb begin
        eos      = s_tuser;
        is_esc   = (mode_reg == scl_pkg::MODE_ESC);
        nl       = !eos && (s_tdata == scl_pkg::CH_NL);
        c        = (nl && !is_esc) ? scl_pkg::CH_SEMI : s_tdata;
        ws       = !eos && (c == scl_pkg::CH_SPACE || c == scl_pkg::CH_TAB ||
                            c == scl_pkg::CH_VT || c == scl_pkg::CH_NL);
        dt       = scl_pkg::delim_type(c);
        dl       = !eos && (dt != scl_pkg::TT_WORD);
        prt      = (c >= scl_pkg::CH_SPACE) && (c <= scl_pkg::CH_TILDE);
        spc      = (c == scl_pkg::CH_SPACE) || ((c >= scl_pkg::CH_TAB) && (c <= scl_pkg::CH_CR));
        bad      = is_esc ? (eos || (!prt && !spc)) : (!eos && !ws && !dl && !prt);
        is_quote = !eos && (c == scl_pkg::CH_QUOTE);
        is_bsl   = !eos && (c == scl_pkg::CH_BSLASH);
        pair     = dl && (dt == dtype_reg) &&
                   (dt == scl_pkg::TT_AMP || dt == scl_pkg::TT_PIPE || dt == scl_pkg::TT_GT);
    end

    // What a character does from the waiting-for-token position
    always_comb begin
        st_append = !eos && !ws && !is_quote && !is_bsl;
        if (eos || ws) begin
            st_mode = scl_pkg::MODE_WAIT;
        end else if (dl) begin
            st_mode = scl_pkg::MODE_DELIM;
        end else if (is_quote || is_bsl) begin
            st_mode = scl_pkg::MODE_ESC;
        end else begin
            st_mode = scl_pkg::MODE_WORD;
        end
    end

    // Action for the current mode
    always_comb begin
        do_flush   = 1'b0;
        flush_type = scl_pkg::TT_WORD;
        do_append  = st_append;
        mode_dec   = st_mode;
        quotes_dec = quotes_reg | is_quote;
        set_halt   = eos;
        unique case (mode_reg)
            scl_pkg::MODE_WORD: begin
                do_flush = eos || ws || dl;
            end
            scl_pkg::MODE_DELIM: begin
                if (pair) begin
                    do_append = 1'b1;
                    mode_dec  = scl_pkg::MODE_DBL;
                end else begin
                    do_flush   = 1'b1;
                    flush_type = dtype_reg;
                end
            end
            scl_pkg::MODE_DBL: begin
                do_flush   = 1'b1;
                flush_type = scl_pkg::pair_type(dtype_reg);
            end
            scl_pkg::MODE_ESC: begin
                set_halt = 1'b0;
                if (is_quote && quotes_reg) begin
                    do_append  = 1'b0;
                    quotes_dec = 1'b0;
                    mode_dec   = scl_pkg::MODE_WORD;
                end else begin
                    do_append  = 1'b1;
                    quotes_dec = quotes_reg;
                    mode_dec   = quotes_reg ? scl_pkg::MODE_ESC : scl_pkg::MODE_WORD;
                end
            end
            default: begin
                do_flush = 1'b0;
            end
        endcase
    end

    // Read-out position
    assign count_empty = (count_reg == '0);
    assign flush_last  = count_empty || ((CW'(ptr_reg) + CW'(1)) == count_reg);
    assign room        = (count_reg < CW'(MAX_WORD));

    assign status_o.err_req    = halted_reg || bad;
    assign status_o.flush_req  = do_flush;
    assign status_o.out_free   = !out_valid_reg || m_tready;
    assign status_o.flush_last = flush_last;

    // State update
    always_comb begin
        mode_next      = mode_reg;
        quotes_next    = quotes_reg;
        halted_next    = halted_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        line_next      = line_reg;
        dtype_next     = dtype_reg;
        ftype_next     = ftype_reg;
        pend_next      = pend_reg;
        pend_char_next = pend_char_reg;
        ptr_next       = ptr_reg;
        err_stat_next  = err_stat_reg;
        ram_we         = 1'b0;
        ram_waddr      = count_reg[AW-1:0];
        ram_wdata      = c;

        if (cmd_i.accept) begin
            ptr_next = '0;
            if (halted_reg || bad) begin
                err_stat_next = halted_reg ? scl_pkg::STAT_AFTER_END : scl_pkg::STAT_BAD_CHAR;
            end else begin
                if (nl && (line_reg != '1)) begin
                    line_next = line_reg + LW'(1);
                end
                mode_next      = mode_dec;
                quotes_next    = quotes_dec;
                halted_next    = halted_reg | set_halt;
                ftype_next     = flush_type;
                pend_next      = do_flush && do_append;
                pend_char_next = c;
                if (mode_dec == scl_pkg::MODE_DELIM) begin
                    dtype_next = dt;
                end
                // Append at once when no token goes out first
                if (!do_flush && do_append) begin
                    if (room) begin
                        ram_we     = 1'b1;
                        count_next = count_reg + CW'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                end
            end
        end

        if (cmd_i.load_byte) begin
            ptr_next = ptr_reg + AW'(1);
        end

        // Token gone: start afresh, with the held character if any
        if (cmd_i.flush_done) begin
            ovf_next   = 1'b0;
            count_next = pend_reg ? CW'(1) : '0;
            pend_next  = 1'b0;
            if (pend_reg) begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = pend_char_reg;
            end
        end
    end

    // Output register
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_type_next   = out_type_reg;
        out_byte_next   = out_byte_reg;
        out_empty_next  = out_empty_reg;
        out_line_next   = out_line_reg;
        out_ovf_next    = out_ovf_reg;
        out_last_next   = out_last_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (cmd_i.load_byte) begin
            out_valid_next  = 1'b1;
            out_status_next = scl_pkg::STAT_TOKEN;
            out_type_next   = ftype_reg;
            out_byte_next   = count_empty ? 8'h00 : ram_rdata;
            out_empty_next  = count_empty;
            out_line_next   = line_reg;
            out_ovf_next    = ovf_reg;
            out_last_next   = flush_last;
        end else if (cmd_i.load_err) begin
            out_valid_next  = 1'b1;
            out_status_next = err_stat_reg;
            out_type_next   = scl_pkg::TT_WORD;
            out_byte_next   = 8'h00;
            out_empty_next  = 1'b0;
            out_line_next   = line_reg;
            out_ovf_next    = 1'b0;
            out_last_next   = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= scl_pkg::MODE_WAIT;
            quotes_reg    <= 1'b0;
            halted_reg    <= 1'b0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            line_reg      <= LW'(1);
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            mode_reg      <= mode_next;
            quotes_reg    <= quotes_next;
            halted_reg    <= halted_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            line_reg      <= line_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        dtype_reg      <= dtype_next;
        ftype_reg      <= ftype_next;
        pend_char_reg  <= pend_char_next;
        ptr_reg        <= ptr_next;
        err_stat_reg   <= err_stat_next;
        out_status_reg <= out_status_next;
        out_type_reg   <= out_type_next;
        out_byte_reg   <= out_byte_next;
        out_empty_reg  <= out_empty_next;
        out_line_reg   <= out_line_next;
        out_ovf_reg    <= out_ovf_next;
        out_last_reg   <= out_last_next;
    end

    // Word store, read address runs one step ahead of ptr_reg
    scl_ram #(
        .WIDTH (8),
        .DEPTH (MAX_WORD)
    ) u_word_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ptr_next),
        .rdata (ram_rdata)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_line_reg, out_byte_reg};
    assign m_tuser  = {out_ovf_reg, out_empty_reg, out_type_reg, out_status_reg};
    assign m_tlast  = out_last_reg;

    // Word length never passes the store size
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_WORD))
        else $error("word count beyond store size");

    // Line count starts at one and never wraps to zero
    a_line_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        line_reg != '0)
        else $error("line count is zero");

    // End of stream is final
    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg |=> halted_reg)
        else $error("halted flag cleared");

    // After a token leaves, at most the held character remains and overflow is clear
    a_flush_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_i.flush_done |=> (count_reg <= CW'(1)) && !ovf_reg && !pend_reg)
        else $error("word state not cleared after token");

endmodule

[src/shell_command_lexer.sv]
// Top level of the shell command lexer: controller, datapath and stream ports.
//
// Byte-at-a-time shell lexer. Each input beat carries one character (s_tuser low) or an
// end-of-stream mark (s_tuser high). Characters that continue a word are taken without
// holding the input. A beat that completes a token holds the input while the word store
// is read out through its single read port, one result beat per byte (a single beat for an
// empty token) with m_tlast on the final one; an error beat also holds the input until its
// result beat is loaded. A finished result waits in the output register, and the next
// character can be taken meanwhile. The word store needs no clearing after reset. Words
// longer than MAX_WORD characters are cut and flagged.
module shell_command_lexer #(
    parameter int MAX_WORD = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tuser,   // [0] kind: 0 character, 1 end of stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] text_byte, [23:8] line_number
    output logic [7:0]  m_tuser,   // [1:0] status, [5:2] token_type, [6] empty_word,
                                   // [7] overflowed
    output logic        m_tlast
);

    scl_pkg::scl_cmd_t    cmd;
    scl_pkg::scl_status_t status;

    scl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status_i (status),
        .cmd_o    (cmd)
    );

    scl_datapath #(
        .MAX_WORD (MAX_WORD)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd_i    (cmd),
        .status_o (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for shell_command_lexer: directed table, random commands, long quoted run.
module tb_top;

    localparam int   MAX_WORD     = 64;
    localparam int   IDLE_LIMIT   = 3000;
    localparam int   HOLD_CYCLES  = 400;
    localparam int   HOLD_AFTER   = 20;
    localparam int   TAIL_CYCLES  = 30;
    localparam int   QUOTED_LINES = 66;   // just past the word store, so the word overflows
    localparam int   RAND_CHARS   = 70;
    localparam int   DIR_ROWS     = 32;
    localparam logic KIND_CHAR    = 1'b0;
    localparam logic KIND_END     = 1'b1;
    localparam logic [7:0] CH_FF  = 8'h0C;

    // One result beat, field by field
    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  ttype;
        logic [7:0]  text;
        logic        empty;
        logic [15:0] line;
        logic        ovf;
        logic        last;
    } token_beat_t;

    // Directed stimulus row; pinned rows carry their error beat typed in
    typedef struct packed {
        logic        kind;
        logic [7:0]  ch;
        logic        pinned;
        logic [1:0]  status;
        logic [15:0] line;
    } dir_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] ch
    logic        s_tuser;   // [0] kind
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // [7:0] text_byte, [23:8] line_number
    logic [7:0]  m_tuser;   // [1:0] status, [5:2] token_type, [6] empty_word, [7] overflowed
    logic        m_tlast;

    shell_command_lexer DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Lexer shadow state
    scl_pkg::mode_t lx_mode;
    logic           lx_inq;
    logic [7:0]     lx_store [MAX_WORD];
    int             lx_count;
    logic [15:0]    lx_line;
    logic           lx_ovf;
    logic           lx_halted;
    token_beat_t    token_beats_due [$];

    int chars_sent;
    int beats_seen  = 0;
    int bad_beats   = 0;
    int fault_count = 0;
    int burst_left;
    bit hold_done   = 1'b0;

    logic [7:0] delim_set [9] = '{"&", "|", ";", "<", ">", "(", ")", "{", "}"};

    dir_row_t dir_tab [DIR_ROWS] = '{
        '{KIND_CHAR, 8'h00,              1'b1, scl_pkg::STAT_BAD_CHAR, 16'd1},  // NUL at start
        '{KIND_CHAR, "a",                1'b0, scl_pkg::STAT_TOKEN,    16'd0},
        '{KIND_CHAR, scl_pkg::CH_TILDE,  1'b0, scl_pkg::STAT_TOKEN,    16'd0},
        '{KIND_CHAR, scl_pkg::CH_SPACE,  1'b0, scl_pkg::STAT_TOKEN,    16'd0},
        '{KIND_CHAR, 8'hFF,              1'b1, scl_pkg::STAT_BAD_CHAR, 16'd1},  // top byte
        '{KIND_CHAR, "&",                1'b0, scl_pkg::STAT_TOKEN,    16'd0},
        '{KIND_CHAR, "&",                1'b0, scl_pkg::STAT_TOKEN,    16'd0},
        '{KIND_CHAR, "x",                1'b0, scl_pkg::STAT_TOKEN,    16'd0},  // kept after &&
        '{KIND_CHAR, ">",                1'b0, scl_pkg::STAT_TOKEN,    16'd0},
        '{KIND_CHAR, ">",                1'b0, scl_pkg::STAT_TOKEN,    16'd0},
        '{KIND_CHAR, "|",                1'b0, scl_pkg::STAT_TOKEN,    16'd0},
        '{KIND_CHAR, "|",                1'b0, scl_pkg::STAT_TOKEN,    16'd0},
        '{KIND_CHAR, scl_pkg::CH_QUOTE,  1'b0, scl_pkg::STAT_TOKEN,    16'd0},
        '{KIND_CHAR, scl_pkg::CH_QUOTE,  1'b0, scl_pkg::STAT_TOKEN,    16'd0},  // empty quotes
        '{KIND_CHAR, scl_pkg::CH_NL,     1'b0, scl_pkg::STAT_TOKEN,    16'd0},  // newline as ';'
        '{KIND_CHAR, scl_pkg::CH_BSLASH, 1'b0, scl_pkg::STAT_TOKEN,    16'd0},
        '{KIND_CHAR, scl_pkg::CH_NL,     1'b0, scl_pkg::STAT_TOKEN,    16'd0},  // escaped newline
        '{KIND_CHAR, scl_pkg::CH_BSLASH, 1'b0, scl_pkg::STAT_TOKEN,    16'd0},
        '{KIND_END,  8'hFF,              1'b1, scl_pkg::STAT_BAD_CHAR, 16'd3},  // end after '\'
        '{KIND_CHAR, scl_pkg::CH_CR,     1'b0, scl_pkg::STAT_TOKEN,    16'd0},  // escaped CR kept
        '{KIND_CHAR, scl_pkg::CH_QUOTE,  1'b0, scl_pkg::STAT_TOKEN,    16'd0},
        '{KIND_CHAR, scl_pkg::CH_BSLASH, 1'b0, scl_pkg::STAT_TOKEN,    16'd0},  // literal in quotes
        '{KIND_END,  8'h00,              1'b1, scl_pkg::STAT_BAD_CHAR, 16'd3},  // end in quotes
        '{KIND_CHAR, scl_pkg::CH_QUOTE,  1'b0, scl_pkg::STAT_TOKEN,    16'd0},
        '{KIND_CHAR, CH_FF,              1'b1, scl_pkg::STAT_BAD_CHAR, 16'd3},  // bare form feed
        '{KIND_CHAR, "(",                1'b0, scl_pkg::STAT_TOKEN,    16'd0},
        '{KIND_CHAR, ")",                1'b0, scl_pkg::STAT_TOKEN,    16'd0},
        '{KIND_CHAR, "{",                1'b0, scl_pkg::STAT_TOKEN,    16'd0},
        '{KIND_CHAR, "}",                1'b0, scl_pkg::STAT_TOKEN,    16'd0},
        '{KIND_CHAR, "<",                1'b0, scl_pkg::STAT_TOKEN,    16'd0},
        '{KIND_CHAR, ";",                1'b0, scl_pkg::STAT_TOKEN,    16'd0},
        '{KIND_CHAR, scl_pkg::CH_VT,     1'b0, scl_pkg::STAT_TOKEN,    16'd0}
    };

    // Clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ---------------- lexer predictor ----------------

    function automatic logic is_blank(input logic [7:0] c);
        return c == scl_pkg::CH_SPACE || c == scl_pkg::CH_TAB ||
               c == scl_pkg::CH_VT || c == scl_pkg::CH_NL;
    endfunction

    function automatic logic is_print(input logic [7:0] c);
        return c >= 8'h20 && c <= 8'h7E;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == scl_pkg::CH_SPACE || (c >= scl_pkg::CH_TAB && c <= scl_pkg::CH_CR);
    endfunction

    function automatic logic [3:0] delim_code(input logic [7:0] c);
        case (c)
            "&":     return scl_pkg::TT_AMP;
            "|":     return scl_pkg::TT_PIPE;
            ";":     return scl_pkg::TT_SEMI;
            "<":     return scl_pkg::TT_LT;
            ">":     return scl_pkg::TT_GT;
            "(":     return scl_pkg::TT_LPAR;
            ")":     return scl_pkg::TT_RPAR;
            "{":     return scl_pkg::TT_LBRACE;
            "}":     return scl_pkg::TT_RBRACE;
            default: return scl_pkg::TT_WORD;
        endcase
    endfunction

    function automatic logic [3:0] pair_code(input logic [7:0] c);
        case (c)
            "&":     return scl_pkg::TT_AND;
            "|":     return scl_pkg::TT_OR;
            ">":     return scl_pkg::TT_APPEND;
            default: return scl_pkg::TT_WORD;
        endcase
    endfunction

    function automatic void push_beat(input logic [1:0] status, input logic [3:0] ttype,
                                      input logic [7:0] text, input logic empty,
                                      input logic ovf, input logic last);
        token_beats_due.push_back(token_beat_t'{status, ttype, text, empty, lx_line, ovf, last});
    endfunction

    function automatic void store_char(input logic [7:0] c);
        if (lx_count < MAX_WORD) begin
            lx_store[lx_count] = c;
            lx_count++;
        end else begin
            lx_ovf = 1'b1;
        end
    endfunction

    // Send the buffered text as one token, one beat per byte
    function automatic void emit_token(input logic [3:0] ttype);
        int i;
        if (lx_count == 0) begin
            push_beat(scl_pkg::STAT_TOKEN, ttype, 8'h00, 1'b1, lx_ovf, 1'b1);
        end else begin
            for (i = 0; i < lx_count; i++)
                push_beat(scl_pkg::STAT_TOKEN, ttype, lx_store[i], 1'b0, lx_ovf,
                          i == lx_count - 1);
        end
        lx_count = 0;
        lx_ovf   = 1'b0;
    endfunction

    // A non-blank character that opens a fresh token
    function automatic void begin_token(input logic [7:0] c);
        if (delim_code(c) != scl_pkg::TT_WORD) begin
            store_char(c);
            lx_mode = scl_pkg::MODE_DELIM;
        end else if (c == scl_pkg::CH_QUOTE) begin
            lx_inq  = 1'b1;
            lx_mode = scl_pkg::MODE_ESC;
        end else if (c == scl_pkg::CH_BSLASH) begin
            lx_mode = scl_pkg::MODE_ESC;
        end else begin
            store_char(c);
            lx_mode = scl_pkg::MODE_WORD;
        end
    endfunction

    function automatic void lex_char(input logic kind, input logic [7:0] c_in);
        logic [7:0]     c;
        logic [7:0]     first;
        logic           eos, nl, ws, dl, bad;
        scl_pkg::mode_t m;
        eos   = (kind == KIND_END);
        c     = c_in;
        m     = (lx_mode > scl_pkg::MODE_ESC) ? scl_pkg::MODE_WAIT : lx_mode;
        first = lx_store[0];
        if (lx_halted) begin
            push_beat(scl_pkg::STAT_AFTER_END, scl_pkg::TT_WORD, 8'h00, 1'b0, 1'b0, 1'b1);
            return;
        end
        nl = !eos && c == scl_pkg::CH_NL;
        if (nl && m != scl_pkg::MODE_ESC)
            c = scl_pkg::CH_SEMI;
        ws = !eos && is_blank(c);
        dl = !eos && delim_code(c) != scl_pkg::TT_WORD;
        if (m == scl_pkg::MODE_ESC)
            bad = eos || (!(c == scl_pkg::CH_QUOTE && lx_inq) && !is_print(c) && !is_space(c));
        else
            bad = !eos && !ws && !dl && !is_print(c);
        // rejected bytes leave every piece of state alone
        if (bad) begin
            push_beat(scl_pkg::STAT_BAD_CHAR, scl_pkg::TT_WORD, 8'h00, 1'b0, 1'b0, 1'b1);
            return;
        end
        if (nl && lx_line != 16'hFFFF)
            lx_line++;

        case (m)
            scl_pkg::MODE_WORD: begin
                if (eos || ws) begin
                    emit_token(scl_pkg::TT_WORD);
                    lx_halted = eos;
                    lx_mode   = scl_pkg::MODE_WAIT;
                end else begin
                    if (dl)
                        emit_token(scl_pkg::TT_WORD);
                    begin_token(c);
                end
            end
            scl_pkg::MODE_DELIM: begin
                if (eos || ws) begin
                    emit_token(delim_code(first));
                    lx_halted = eos;
                    lx_mode   = scl_pkg::MODE_WAIT;
                end else if (pair_code(c) != scl_pkg::TT_WORD && c == first) begin
                    store_char(c);
                    lx_mode = scl_pkg::MODE_DBL;
                end else begin
                    emit_token(delim_code(first));
                    begin_token(c);
                end
            end
            scl_pkg::MODE_DBL: begin
                emit_token(pair_code(first));
                lx_mode = scl_pkg::MODE_WAIT;
                if (eos)
                    lx_halted = 1'b1;
                else if (!ws)
                    begin_token(c);
            end
            scl_pkg::MODE_ESC: begin
                if (c == scl_pkg::CH_QUOTE && lx_inq) begin
                    lx_inq  = 1'b0;
                    lx_mode = scl_pkg::MODE_WORD;
                end else begin
                    store_char(c);
                    if (!lx_inq)
                        lx_mode = scl_pkg::MODE_WORD;
                end
            end
            default: begin
                if (eos)
                    lx_halted = 1'b1;
                else if (!ws)
                    begin_token(c);
            end
        endcase
    endfunction

    // ---------------- input side ----------------

    // One beat on the input, in bursts with random gaps
    task automatic send_beat(input logic kind, input logic [7:0] ch,
                             input logic pinned = 1'b0, input token_beat_t pin = '0);
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tuser  <= kind;
        do @(posedge aclk); while (!s_tready);
        if (pinned)
            token_beats_due.push_back(pin);
        else
            lex_char(kind, ch);
        chars_sent++;
        @(negedge aclk);
    endtask

    // Command-like text: words, blanks, delimiters, quotes, escapes, some noise
    task automatic random_commands(input int n_chars);
        int         stop_at, r, len, i;
        logic [7:0] c;
        stop_at = chars_sent + n_chars;
        while (chars_sent < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                len = ($urandom_range(0, 24) == 0) ? $urandom_range(60, 72)
                                                   : $urandom_range(1, 8);
                for (i = 0; i < len; i++)
                    send_beat(KIND_CHAR, 8'($urandom_range(8'h21, 8'h7E)));
            end else if (r < 55) begin
                case ($urandom_range(0, 3))
                    0:       c = scl_pkg::CH_SPACE;
                    1:       c = scl_pkg::CH_TAB;
                    2:       c = scl_pkg::CH_VT;
                    default: c = scl_pkg::CH_NL;
                endcase
                send_beat(KIND_CHAR, c);
            end else if (r < 70) begin
                c = delim_set[$urandom_range(0, 8)];
                send_beat(KIND_CHAR, c);
                if ($urandom_range(0, 2) == 0)
                    send_beat(KIND_CHAR, c);
            end else if (r < 80) begin
                send_beat(KIND_CHAR, scl_pkg::CH_QUOTE);
                len = $urandom_range(0, 6);
                for (i = 0; i < len; i++) begin
                    case ($urandom_range(0, 9))
                        0:       c = scl_pkg::CH_NL;
                        1:       c = scl_pkg::CH_TAB;
                        2:       c = scl_pkg::CH_BSLASH;
                        3:       c = 8'($urandom_range(0, 255));
                        default: c = 8'($urandom_range(8'h20, 8'h7E));
                    endcase
                    if (c == scl_pkg::CH_QUOTE)
                        c = scl_pkg::CH_SPACE;
                    // end mark only while escaped or quoted, where it is rejected
                    if ($urandom_range(0, 19) == 0 && lx_mode == scl_pkg::MODE_ESC)
                        send_beat(KIND_END, c);
                    send_beat(KIND_CHAR, c);
                end
                send_beat(KIND_CHAR, scl_pkg::CH_QUOTE);
            end else if (r < 88) begin
                send_beat(KIND_CHAR, scl_pkg::CH_BSLASH);
                if ($urandom_range(0, 5) == 0 && lx_mode == scl_pkg::MODE_ESC)
                    send_beat(KIND_END, 8'($urandom_range(0, 255)));
                case ($urandom_range(0, 7))
                    0:       c = scl_pkg::CH_QUOTE;
                    1:       c = scl_pkg::CH_NL;
                    2:       c = scl_pkg::CH_CR;
                    3:       c = CH_FF;
                    4:       c = 8'($urandom_range(0, 255));
                    default: c = 8'($urandom_range(8'h20, 8'h7E));
                endcase
                send_beat(KIND_CHAR, c);
            end else if (r < 97) begin
                send_beat(KIND_CHAR, 8'($urandom_range(0, 255)));
            end else begin
                send_beat(KIND_CHAR, scl_pkg::CH_NL);
            end
        end
    endtask

    // ---------------- result side ----------------

    function automatic string beat_text(input token_beat_t b);
        return $sformatf("st=%0d type=%0d byte=%02h empty=%0d line=%0d ovf=%0d last=%0d",
                         b.status, b.ttype, b.text, b.empty, b.line, b.ovf, b.last);
    endfunction

    function automatic void report_fault(input string msg);
        if (fault_count < 10)
            $display("tb_top: MISMATCH %s", msg);
        fault_count++;
    endfunction

    // Compare each result beat with the oldest one due
    always @(posedge aclk) begin : result_check
        token_beat_t got;
        token_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tuser[1:0], m_tuser[5:2], m_tdata[7:0], m_tuser[6], m_tdata[23:8],
                   m_tuser[7], m_tlast};
            beats_seen++;
            if (got.status != scl_pkg::STAT_TOKEN)
                bad_beats++;
            if (token_beats_due.size() == 0) begin
                report_fault({"unexpected beat: ", beat_text(got)});
            end else begin
                want = token_beats_due.pop_front();
                if (got !== want)
                    report_fault({"expected ", beat_text(want), " got ", beat_text(got)});
            end
        end
    end

    // Receiver readiness: changing patterns, plus one long hold-off
    initial begin : rx_pacer
        int   style, left, hold_left;
        logic rdy;
        m_tready  = 1'b0;
        style     = 0;
        left      = 0;
        hold_left = 0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (!hold_done && beats_seen >= HOLD_AFTER) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else begin
                if (left == 0) begin
                    style = $urandom_range(0, 3);
                    left  = $urandom_range(5, 60);
                end
                left--;
                case (style)
                    0:       rdy = 1'b1;
                    1:       rdy = ($urandom_range(0, 9) < 7);
                    2:       rdy = (left % 3 != 0);
                    default: rdy = ($urandom_range(0, 9) < 3);
                endcase
            end
            m_tready <= rdy;
        end
    end

    // Watchdog on beats moving at either side
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle = 0;
            else
                idle++;
        end
        $display("tb_top: no beat moved for %0d cycles", IDLE_LIMIT);
        $display("tb_top: done, errors");
        $finish;
    end

    // ---------------- main sequence ----------------

    initial begin : stimulus
        int          i;
        dir_row_t    row;
        token_beat_t pin;
        s_tvalid    = 1'b0;
        s_tdata     = 8'h00;
        s_tuser     = KIND_CHAR;
        aresetn     = 1'b0;
        chars_sent  = 0;
        burst_left  = 0;
        lx_mode     = scl_pkg::MODE_WAIT;
        lx_inq      = 1'b0;
        lx_count    = 0;
        lx_line     = 16'd1;
        lx_ovf      = 1'b0;
        lx_halted   = 1'b0;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed table
        for (i = 0; i < DIR_ROWS; i++) begin
            row = dir_tab[i];
            pin = '{row.status, scl_pkg::TT_WORD, 8'h00, 1'b0, row.line, 1'b0, 1'b1};
            send_beat(row.kind, row.ch, row.pinned, pin);
        end

        random_commands(RAND_CHARS);

        // leave any open escape or quote, then a quoted run of newlines that overflows a word
        if (lx_mode == scl_pkg::MODE_ESC)
            send_beat(KIND_CHAR, lx_inq ? scl_pkg::CH_QUOTE : 8'("x"));
        send_beat(KIND_CHAR, scl_pkg::CH_SPACE);
        send_beat(KIND_CHAR, scl_pkg::CH_QUOTE);
        for (i = 0; i < QUOTED_LINES; i++)
            send_beat(KIND_CHAR, scl_pkg::CH_NL);
        send_beat(KIND_CHAR, scl_pkg::CH_QUOTE);
        send_beat(KIND_CHAR, scl_pkg::CH_SPACE);
        send_beat(KIND_CHAR, "z");
        send_beat(KIND_CHAR, scl_pkg::CH_NL);
        send_beat(KIND_CHAR, "q");

        // the one real end of stream, then input past it
        send_beat(KIND_END, 8'h00);
        send_beat(KIND_CHAR, "a");
        send_beat(KIND_END, 8'hFF);
        s_tvalid <= 1'b0;

        while (token_beats_due.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("tb_top: %0d input beats, %0d result beats (%0d errors flagged), %0d faults",
                 chars_sent, beats_seen, bad_beats, fault_count);
        $display("tb_top: line count ended at %0d, long receiver hold-off %s",
                 lx_line, hold_done ? "applied" : "not reached");
        if (fault_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

[files.f]
src/scl_pkg.sv
src/scl_ram.sv
src/scl_ctrl.sv
src/scl_datapath.sv
src/shell_command_lexer.sv
test/tb_top.sv
